[hdl/lfrc_pkg.sv]
// Shared types, constants and the CRC16-Modbus byte update for the
// length-framed receiver. No dependencies.
package lfrc_pkg;

    // Frame geometry defaults
    localparam int MAX_FRAME_BYTES_DEF   = 266;
    localparam int MAX_PAYLOAD_BYTES_DEF = 256;
    localparam int MIN_FRAME_BYTES       = 10;
    localparam int START_FRAME_BYTES     = 17;

    // Byte positions inside a frame
    localparam logic [15:0] POS_CMD_HI   = 16'd1;
    localparam logic [15:0] POS_LEN_HI   = 16'd3;
    localparam logic [15:0] POS_TARGET   = 16'd4;
    localparam logic [15:0] POS_SIZE_B0  = 16'd5;
    localparam logic [15:0] POS_SIZE_B1  = 16'd6;
    localparam logic [15:0] POS_SIZE_B2  = 16'd7;
    localparam logic [15:0] POS_SIZE_B3  = 16'd8;
    localparam logic [15:0] POS_ICRC_B0  = 16'd9;
    localparam logic [15:0] POS_ICRC_B1  = 16'd10;
    localparam logic [15:0] PAYLOAD_OFS  = 16'd4;
    localparam logic [15:0] TRAILER_LEN  = 16'd6;
    localparam logic [15:0] CRC_LEN      = 16'd2;

    // Status codes
    localparam logic [1:0] ST_WAIT  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Frame classes
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_START = 2'd1;
    localparam logic [1:0] CLS_DATA  = 2'd2;
    localparam logic [1:0] CLS_END   = 2'd3;

    // Target slots
    localparam logic [1:0] SLOT_NONE = 2'd0;
    localparam logic [1:0] SLOT_A    = 2'd1;
    localparam logic [1:0] SLOT_B    = 2'd2;
    localparam logic [1:0] SLOT_AUTO = 2'd3;

    // Item kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_START_CMD = 3'd0;
    localparam cfg_idx_t CFG_DATA_CMD  = 3'd1;
    localparam cfg_idx_t CFG_END_CMD   = 3'd2;
    localparam cfg_idx_t CFG_TARGET_A  = 3'd3;
    localparam cfg_idx_t CFG_TARGET_B  = 3'd4;
    localparam cfg_idx_t CFG_TARGET_AU = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // One byte of reflected CRC16-Modbus
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hdl/length_framed_receiver_crc_check.sv]
// Length-framed receiver with running CRC16-Modbus check and frame
// classification. Depends on lfrc_pkg.
//
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle while s_ready is high; the only stage is the output register, and
// s_ready is high whenever that register is empty or being emptied.
// Reset: synchronous active-low aresetn clears the receiver state, the
// configuration registers to their defaults and the output valid.
module length_framed_receiver_crc_check #(
    parameter int MAX_FRAME_BYTES   = lfrc_pkg::MAX_FRAME_BYTES_DEF,
    parameter int MAX_PAYLOAD_BYTES = lfrc_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [lfrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]               cfg_wdata,
    // input items
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_kind,
    input  logic [7:0]                s_rx_byte,
    // result items
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_status,
    output logic [1:0]                m_frame_class,
    output logic [15:0]               m_frame_command,
    output logic [8:0]                m_frame_length,
    output logic [31:0]               m_reserve_value,
    output logic                      m_crc_ok,
    output logic [1:0]                m_target_slot,
    output logic [31:0]               m_image_size,
    output logic [15:0]               m_image_crc,
    output logic                      m_payload_valid,
    output logic [7:0]                m_payload_byte,
    output logic [7:0]                m_payload_index
);
    import lfrc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [15:0]      LEN_MAX   = 16'(MAX_FRAME_BYTES);
    localparam logic [15:0]      LEN_MIN   = 16'(MIN_FRAME_BYTES);
    localparam logic [15:0]      LEN_START = 16'(START_FRAME_BYTES);
    localparam logic [15:0]      LEN_DMAX  = 16'(MAX_PAYLOAD_BYTES + MIN_FRAME_BYTES);

    // Configuration registers
    logic [15:0] start_cmd_reg, data_cmd_reg, end_cmd_reg;
    logic [7:0]  tgt_a_reg, tgt_b_reg, tgt_auto_reg;

    // Receiver state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] exp_reg, exp_next;
    logic             held_reg, held_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      hdr_reg, hdr_next;
    logic [7:0]       rb_reg [6];
    logic [7:0]       rb_next [6];
    logic [7:0]       tgt_reg, tgt_next;
    logic [31:0]      size_reg, size_next;
    logic [15:0]      icrc_reg, icrc_next;

    // Result being formed
    logic        res_report;
    logic        res_error;
    logic        res_pv;
    logic [7:0]  res_pb;
    logic [7:0]  res_pi;
    logic [15:0] cnt16, exp16, len_hdr;
    logic [15:0] rx_crc;
    logic [31:0] reserve;
    logic        ok;
    logic [1:0]  slot;
    logic [1:0]  cls;

    // Output register
    logic        m_valid_reg;
    logic [1:0]  status_reg, class_reg, slot_reg;
    logic [15:0] cmd_reg, img_crc_reg;
    logic [8:0]  len_reg;
    logic [31:0] reserve_reg, img_size_reg;
    logic        crc_ok_reg, pv_reg;
    logic [7:0]  pb_reg, pi_reg;

    logic s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_cmd_reg <= 16'd1;
            data_cmd_reg  <= 16'd2;
            end_cmd_reg   <= 16'd3;
            tgt_a_reg     <= 8'd1;
            tgt_b_reg     <= 8'd2;
            tgt_auto_reg  <= 8'd3;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_CMD: start_cmd_reg <= cfg_wdata;
                CFG_DATA_CMD:  data_cmd_reg  <= cfg_wdata;
                CFG_END_CMD:   end_cmd_reg   <= cfg_wdata;
                CFG_TARGET_A:  tgt_a_reg     <= cfg_wdata[7:0];
                CFG_TARGET_B:  tgt_b_reg     <= cfg_wdata[7:0];
                CFG_TARGET_AU: tgt_auto_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Per-item state update
    always_comb begin
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        held_next  = held_reg;
        crc_next   = crc_reg;
        hdr_next   = hdr_reg;
        rb_next    = rb_reg;
        tgt_next   = tgt_reg;
        size_next  = size_reg;
        icrc_next  = icrc_reg;
        res_report = 1'b0;
        res_error  = 1'b0;
        res_pv     = 1'b0;
        res_pb     = 8'd0;
        res_pi     = 8'd0;
        cnt16      = 16'(cnt_reg);
        exp16      = 16'(exp_reg);
        len_hdr    = {s_rx_byte, rb_reg[0]};

        if (s_kind == KIND_RELEASE) begin
            cnt_next  = '0;
            exp_next  = '0;
            held_next = 1'b0;
            crc_next  = CRC_INIT;
        end else if (held_reg) begin
            // held frame: byte dropped, report repeated
            res_report = 1'b1;
        end else if (cnt_reg >= CNT_MAX) begin
            cnt_next  = '0;
            exp_next  = '0;
            held_next = 1'b0;
            crc_next  = CRC_INIT;
            res_error = 1'b1;
        end else begin
            // history of recent bytes, newest at index 0
            rb_next[0] = s_rx_byte;
            for (int k = 1; k < 6; k++) begin
                rb_next[k] = rb_reg[k-1];
            end

            // CRC covers everything but the final two bytes
            if (cnt16 < PAYLOAD_OFS ||
                (exp16 >= CRC_LEN && cnt16 < exp16 - CRC_LEN)) begin
                crc_next = crc_update(crc_reg, s_rx_byte);
            end

            // start payload capture
            case (cnt16)
                POS_TARGET:  tgt_next         = s_rx_byte;
                POS_SIZE_B0: size_next        = {24'd0, s_rx_byte};
                POS_SIZE_B1: size_next[15:8]  = s_rx_byte;
                POS_SIZE_B2: size_next[23:16] = s_rx_byte;
                POS_SIZE_B3: size_next[31:24] = s_rx_byte;
                POS_ICRC_B0: icrc_next        = {8'd0, s_rx_byte};
                POS_ICRC_B1: icrc_next[15:8]  = s_rx_byte;
                default: ;
            endcase

            // payload pass-through
            if (exp16 >= TRAILER_LEN && cnt16 >= PAYLOAD_OFS &&
                cnt16 < exp16 - TRAILER_LEN) begin
                res_pv = 1'b1;
                res_pb = s_rx_byte;
                res_pi = 8'(cnt16 - PAYLOAD_OFS);
            end

            cnt_next = cnt_reg + 1'b1;

            if (cnt16 == POS_CMD_HI) begin
                hdr_next = len_hdr;
            end

            // header length check at the fourth byte
            if (cnt16 == POS_LEN_HI) begin
                if (len_hdr < LEN_MIN || len_hdr > LEN_MAX) begin
                    cnt_next  = '0;
                    exp_next  = '0;
                    held_next = 1'b0;
                    crc_next  = CRC_INIT;
                    res_error = 1'b1;
                end else begin
                    exp_next = CNT_W'(len_hdr);
                end
            end

            // frame complete
            if (exp_next != '0 && cnt_next == exp_next) begin
                held_next  = 1'b1;
                res_report = 1'b1;
            end
        end
    end

    // Frame check and classification on the post-update state
    always_comb begin
        rx_crc  = {rb_next[0], rb_next[1]};
        reserve = {rb_next[2], rb_next[3], rb_next[4], rb_next[5]};
        ok      = (rx_crc == crc_next);

        if (tgt_next == tgt_a_reg) begin
            slot = SLOT_A;
        end else if (tgt_next == tgt_b_reg) begin
            slot = SLOT_B;
        end else if (tgt_next == tgt_auto_reg) begin
            slot = SLOT_AUTO;
        end else begin
            slot = SLOT_NONE;
        end

        if (hdr_next == start_cmd_reg && 16'(exp_next) == LEN_START && ok &&
            slot != SLOT_NONE && size_next != 32'd0) begin
            cls = CLS_START;
        end else if (hdr_next == data_cmd_reg && 16'(exp_next) > LEN_MIN &&
                     16'(exp_next) <= LEN_DMAX && ok) begin
            cls = CLS_DATA;
        end else if (hdr_next == end_cmd_reg && 16'(exp_next) == LEN_MIN && ok &&
                     reserve != 32'd0) begin
            cls = CLS_END;
        end else begin
            cls = CLS_NONE;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            exp_reg  <= '0;
            held_reg <= 1'b0;
            crc_reg  <= CRC_INIT;
            hdr_reg  <= 16'd0;
            for (int k = 0; k < 6; k++) begin
                rb_reg[k] <= 8'd0;
            end
            tgt_reg  <= 8'd0;
            size_reg <= 32'd0;
            icrc_reg <= 16'd0;
        end else if (s_fire) begin
            cnt_reg  <= cnt_next;
            exp_reg  <= exp_next;
            held_reg <= held_next;
            crc_reg  <= crc_next;
            hdr_reg  <= hdr_next;
            rb_reg   <= rb_next;
            tgt_reg  <= tgt_next;
            size_reg <= size_next;
            icrc_reg <= icrc_next;
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg   <= res_report ? ST_READY : (res_error ? ST_ERROR : ST_WAIT);
            class_reg    <= res_report ? cls : CLS_NONE;
            cmd_reg      <= res_report ? hdr_next : 16'd0;
            len_reg      <= res_report ? 9'(exp_next) : 9'd0;
            reserve_reg  <= res_report ? reserve : 32'd0;
            crc_ok_reg   <= res_report && ok;
            slot_reg     <= (res_report && cls == CLS_START) ? slot : SLOT_NONE;
            img_size_reg <= (res_report && cls == CLS_START) ? size_next : 32'd0;
            img_crc_reg  <= (res_report && cls == CLS_START) ? icrc_next : 16'd0;
            pv_reg       <= res_pv;
            pb_reg       <= res_pb;
            pi_reg       <= res_pi;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_frame_class   = class_reg;
    assign m_frame_command = cmd_reg;
    assign m_frame_length  = len_reg;
    assign m_reserve_value = reserve_reg;
    assign m_crc_ok        = crc_ok_reg;
    assign m_target_slot   = slot_reg;
    assign m_image_size    = img_size_reg;
    assign m_image_crc     = img_crc_reg;
    assign m_payload_valid = pv_reg;
    assign m_payload_byte  = pb_reg;
    assign m_payload_index = pi_reg;

    // A held frame always sits exactly at its declared length
    a_held_at_len: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> (exp_reg != '0 && cnt_reg == exp_reg))
        else $error("held frame without a complete count");

    // A latched length is always inside the legal range
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (exp_reg != '0) |-> (16'(exp_reg) >= LEN_MIN && 16'(exp_reg) <= LEN_MAX))
        else $error("expected length out of range");

    // A release leaves the receiver empty and reports waiting
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_kind == KIND_RELEASE) |=>
            (m_valid && m_status == ST_WAIT && !held_reg && cnt_reg == '0))
        else $error("release did not clear the receiver");

    // Payload bytes are only reported while waiting for frame end
    a_payload_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload_valid) |-> (m_status == ST_WAIT))
        else $error("payload byte reported with a frame status");

endmodule
